// ===== hdl/assert_macros.svh =====
// assertion macros shared by the decoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on the rising clock, masked while reset is asserted
`define RPS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// property checked on every rising clock, also during reset
`define RPS_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/rps_pkg.sv =====
// package: constants, register indexes and shared types of the span decoder
package rps_pkg;

    localparam int IMAGE_WIDTH   = 240;
    localparam int IMAGE_HEIGHT  = 240;
    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_AW        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    // command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    // configuration register indexes
    localparam logic [7:0] CFG_FIRST_COL = 8'd0;
    localparam logic [7:0] CFG_LAST_COL  = 8'd1;
    localparam logic [7:0] CFG_FIRST_ROW = 8'd2;
    localparam logic [7:0] CFG_LAST_ROW  = 8'd3;

    // register reset values
    localparam logic [7:0] RST_FIRST_COL = 8'd0;
    localparam logic [7:0] RST_LAST_COL  = 8'd239;
    localparam logic [7:0] RST_FIRST_ROW = 8'd0;
    localparam logic [7:0] RST_LAST_ROW  = 8'd239;

    typedef struct packed {
        logic [7:0] first_col;
        logic [7:0] last_col;
        logic [7:0] first_row;
        logic [7:0] last_row;
    } clip_cfg_t;

    // result of the span logic for one run
    typedef struct packed {
        logic       visible;
        logic [7:0] span_first;
        logic [7:0] span_last;
        logic       line_end;
        logic       frame_done;
        logic [7:0] col_next;
        logic [7:0] row_next;
    } span_res_t;

endpackage

// ===== hdl/rps_if.sv =====
// channel interfaces: run input, span output and configuration write
interface rps_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [7:0]  run_count;
    logic [7:0]  color_index;
    logic [15:0] palette_color;

    modport source (output valid, command, run_count, color_index, palette_color,
                    input ready);
    modport sink   (input valid, command, run_count, color_index, palette_color,
                    output ready);
endinterface

interface rps_out_if;
    logic        valid;
    logic        ready;
    logic        visible;
    logic [7:0]  row;
    logic [7:0]  span_first;
    logic [7:0]  span_last;
    logic [15:0] color565;
    logic [7:0]  red8;
    logic [7:0]  green8;
    logic [7:0]  blue8;
    logic        line_end;
    logic        frame_done;

    modport source (output valid, visible, row, span_first, span_last, color565,
                    red8, green8, blue8, line_end, frame_done,
                    input ready);
    modport sink   (input valid, visible, row, span_first, span_last, color565,
                    red8, green8, blue8, line_end, frame_done,
                    output ready);
endinterface

interface rps_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/rps_palette_ram.sv =====
// palette memory: one write port, one registered read port
module rps_palette_ram
    import rps_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [PAL_AW-1:0] wr_addr,
    input  logic [15:0]       wr_data,
    input  logic              rd_en,
    input  logic [PAL_AW-1:0] rd_addr,
    output logic [15:0]       rd_data
);

    logic [15:0] mem [PALETTE_DEPTH];
    logic [15:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/rps_cfg_regs.sv =====
// clip window registers written over the configuration channel
module rps_cfg_regs
    import rps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    rps_cfg_if.sink   cfg,
    output clip_cfg_t clip
);

    clip_cfg_t clip_reg;
    clip_cfg_t clip_next;

    assign cfg.ready = 1'b1;

    // register decode
    always_comb
    begin
        clip_next = clip_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_FIRST_COL: clip_next.first_col = cfg.data;
                CFG_LAST_COL:  clip_next.last_col  = cfg.data;
                CFG_FIRST_ROW: clip_next.first_row = cfg.data;
                CFG_LAST_ROW:  clip_next.last_row  = cfg.data;
                default:       clip_next = clip_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_reg.first_col <= RST_FIRST_COL;
            clip_reg.last_col  <= RST_LAST_COL;
            clip_reg.first_row <= RST_FIRST_ROW;
            clip_reg.last_row  <= RST_LAST_ROW;
        end
        else
        begin
            clip_reg <= clip_next;
        end
    end

    assign clip = clip_reg;

endmodule

// ===== hdl/rps_span_calc.sv =====
// span logic: clamp the run, cut it to the clip window, step column and row
module rps_span_calc
    import rps_pkg::*;
(
    input  logic [7:0] col,
    input  logic [7:0] row,
    input  logic [7:0] run_count,
    input  clip_cfg_t  clip,
    output span_res_t  res
);

    localparam logic [8:0] WIDTH9  = 9'(IMAGE_WIDTH);
    localparam logic [8:0] HEIGHT9 = 9'(IMAGE_HEIGHT);

    logic [8:0] end_raw;
    logic [8:0] end_clamped;
    logic [7:0] last_px;
    logic [7:0] lo;
    logic [7:0] hi;
    logic       row_in;
    logic       zero_run;
    logic       lend;
    logic [8:0] row_inc;

    always_comb
    begin
        zero_run = (run_count == 8'd0);

        // run end, clamped to the image width
        end_raw     = {1'b0, col} + {1'b0, run_count};
        end_clamped = (end_raw > WIDTH9) ? WIDTH9 : end_raw;
        last_px     = 8'(end_clamped - 9'd1);

        // cut to the clip window
        lo     = (col > clip.first_col) ? col : clip.first_col;
        hi     = (last_px < clip.last_col) ? last_px : clip.last_col;
        row_in = (row >= clip.first_row) && (row <= clip.last_row);

        res.visible    = !zero_run && (lo <= hi) && row_in;
        res.span_first = res.visible ? lo : 8'd0;
        res.span_last  = res.visible ? hi : 8'd0;

        // line and frame stepping
        lend         = zero_run || (end_clamped >= WIDTH9);
        row_inc      = {1'b0, row} + 9'd1;
        res.line_end = lend;
        res.frame_done = lend && (row_inc >= HEIGHT9);
        if (lend)
        begin
            res.col_next = 8'd0;
            res.row_next = res.frame_done ? 8'd0 : row_inc[7:0];
        end
        else
        begin
            res.col_next = end_clamped[7:0];
            res.row_next = row;
        end
    end

endmodule

// ===== hdl/rle_palette_span_decoder.sv =====
// top level: run-length palette span decoder
//
// Takes one beat per cycle on run_in unless the output stalls: a load beat
// writes one palette word, a run beat yields one span beat on span_out via
// the stage 1 and output registers. Span, line and frame flags are worked out
// in the accept cycle from the column and row counters; the palette word comes
// from the registered read port of the palette memory at the same edge, and
// the color is formed into the output register. A load followed directly by
// a run that uses the same entry sees the new word. Write the clip window on
// cfg only while the decoder is idle, unchecked by the block; cfg is always
// ready. The palette has no reset: a run must only use entries already loaded.
module rle_palette_span_decoder
    import rps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    rps_in_if.sink    run_in,
    rps_out_if.source span_out,
    rps_cfg_if.sink   cfg
);

`include "assert_macros.svh"

    clip_cfg_t   clip;
    span_res_t   span;
    logic [15:0] pal_rd;

    logic        accept;
    logic        run_acc;
    logic        load_acc;
    logic        idx_ok;
    logic        s1_adv;

    logic [7:0]  col_reg;
    logic [7:0]  row_reg;

    // stage 1: span results waiting for the palette word
    logic        s1_valid_reg;
    logic        s1_visible_reg;
    logic [7:0]  s1_row_reg;
    logic [7:0]  s1_first_reg;
    logic [7:0]  s1_last_reg;
    logic        s1_nocolor_reg;
    logic        s1_lend_reg;
    logic        s1_fend_reg;

    // output register
    logic        out_valid_reg;
    logic        out_visible_reg;
    logic [7:0]  out_row_reg;
    logic [7:0]  out_first_reg;
    logic [7:0]  out_last_reg;
    logic [15:0] out_color_reg;
    logic        out_lend_reg;
    logic        out_fend_reg;
    logic [15:0] color_next;

    rps_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .clip  (clip)
    );

    rps_span_calc u_span (
        .col       (col_reg),
        .row       (row_reg),
        .run_count (run_in.run_count),
        .clip      (clip),
        .res       (span)
    );

    // handshake and index range
    assign s1_adv   = !out_valid_reg || span_out.ready;
    assign run_in.ready = !s1_valid_reg || s1_adv;
    assign accept   = run_in.valid && run_in.ready;
    assign run_acc  = accept && (run_in.command == CMD_RUN);
    assign load_acc = accept && (run_in.command == CMD_LOAD);
    assign idx_ok   = ({1'b0, run_in.color_index} < 9'(PALETTE_DEPTH));

    rps_palette_ram u_pal (
        .clk     (clk),
        .wr_en   (load_acc && idx_ok),
        .wr_addr (run_in.color_index[PAL_AW-1:0]),
        .wr_data (run_in.palette_color),
        .rd_en   (run_acc),
        .rd_addr (run_in.color_index[PAL_AW-1:0]),
        .rd_data (pal_rd)
    );

    // column and row counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= 8'd0;
            row_reg <= 8'd0;
        end
        else if (run_acc)
        begin
            col_reg <= span.col_next;
            row_reg <= span.row_next;
        end
    end

    // stage 1 valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (run_acc)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // stage 1 payload
    always_ff @(posedge clk)
    begin
        if (run_acc)
        begin
            s1_visible_reg <= span.visible;
            s1_row_reg     <= row_reg;
            s1_first_reg   <= span.span_first;
            s1_last_reg    <= span.span_last;
            s1_nocolor_reg <= (run_in.run_count == 8'd0) || !idx_ok;
            s1_lend_reg    <= span.line_end;
            s1_fend_reg    <= span.frame_done;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    // output payload
    assign color_next = s1_nocolor_reg ? 16'd0 : pal_rd;

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
        begin
            out_visible_reg <= s1_visible_reg;
            out_row_reg     <= s1_row_reg;
            out_first_reg   <= s1_first_reg;
            out_last_reg    <= s1_last_reg;
            out_color_reg   <= color_next;
            out_lend_reg    <= s1_lend_reg;
            out_fend_reg    <= s1_fend_reg;
        end
    end

    // output channel, color expanded to 8 bits per component
    assign span_out.valid      = out_valid_reg;
    assign span_out.visible    = out_visible_reg;
    assign span_out.row        = out_row_reg;
    assign span_out.span_first = out_first_reg;
    assign span_out.span_last  = out_last_reg;
    assign span_out.color565   = out_color_reg;
    assign span_out.red8       = {out_color_reg[15:11], 3'b000};
    assign span_out.green8     = {out_color_reg[10:5], 2'b00};
    assign span_out.blue8      = {out_color_reg[4:0], 3'b000};
    assign span_out.line_end   = out_lend_reg;
    assign span_out.frame_done = out_fend_reg;

    // checks
    `RPS_ASSERT_ALWAYS(a_col_in_image, col_reg < 8'(IMAGE_WIDTH), "column past width")
    `RPS_ASSERT_ALWAYS(a_row_in_image, row_reg < 8'(IMAGE_HEIGHT), "row past height")
    `RPS_ASSERT(a_frame_needs_line, out_valid_reg && out_fend_reg |-> out_lend_reg, "lone frame")
    `RPS_ASSERT(a_span_ordered, out_valid_reg && out_visible_reg |-> out_first_reg <= out_last_reg, "order")
    `RPS_ASSERT(a_no_overrun, s1_valid_reg && !s1_adv |-> !accept, "beat into stalled stage")

endmodule
